### src/enw_pkg.sv
// Shared types and constants for the escalating network watchdog.
// No dependencies; imported by every module of the block.
package enw_pkg;

  localparam int unsigned MIN_W   = 16;
  localparam int unsigned MS_W    = 32;
  localparam int unsigned IFC_W   = 16;
  localparam int unsigned SYS_W   = 8;
  localparam int unsigned TMO_W   = 8;
  localparam int unsigned ACT_W   = 2;
  localparam int unsigned PADDR_W = 3;

  localparam logic [MIN_W-1:0] GROWTH           = 16'd2;
  localparam logic [MIN_W-1:0] MAX_WAIT_MINUTES = 16'd1440;
  localparam logic [MIN_W-1:0] MS_PER_MINUTE    = 16'd60000;
  localparam logic [IFC_W-1:0] IFC_MAX          = '1;
  localparam logic [SYS_W-1:0] SYS_MAX          = '1;

  localparam logic REG_TIMEOUT = 1'b0;

  typedef enum logic [ACT_W-1:0] {
    ACT_NONE   = 2'd0,
    ACT_IFACE  = 2'd1,
    ACT_SYSTEM = 2'd2
  } action_e;

  typedef enum logic [5:0] {
    ST_IDLE        = 6'b000001,
    ST_GROW        = 6'b000010,
    ST_SCALE_WAIT  = 6'b000100,
    ST_SCALE_IFACE = 6'b001000,
    ST_DECIDE      = 6'b010000,
    ST_OUT         = 6'b100000
  } state_e;

endpackage

### src/escalating_network_watchdog.sv
// Top level of the escalating network watchdog: APB register, sequencer, state.
// Depends on enw_pkg and enw_mul.
//
//   Channel | Dir | Request content
//   s_axis  | in  | tuser: link_ok; tdata: now_ms
//   m_axis  | out | tuser: action; tdata: outage_ms, iface total, system count
//   APB     | in  | register 0 at byte address 0: timeout_minutes
//
// A down request with a nonzero timeout keeps the input busy through the backoff
// multiply steps and the scale, decide and output states; the step count is the system
// restart count, stopped early once the wait reaches its cap, so at most 11 steps.
// Other requests go straight to the output state. All steps share one multiplier under
// the sequencer. Reset clears control state and the timeout register; no clearing pass
// is needed. A held result stalls only the last step; then the input is taken again.
module escalating_network_watchdog import enw_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [31:0]        s_axis_tdata,  // now_ms[31:0]
  input  logic [0:0]         s_axis_tuser,  // link_ok[0]
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [55:0]        m_axis_tdata,  // outage_ms[31:0], iface[47:32], sys[55:48]
  output logic [1:0]         m_axis_tuser,  // action[1:0]
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  state_e           state_q, state_d;
  logic [TMO_W-1:0] timeout_q, timeout_d;
  logic             is_down_q, is_down_d;
  logic [MS_W-1:0]  down_since_q, down_since_d;
  logic             iface_fired_q, iface_fired_d;
  logic             sys_fired_q, sys_fired_d;
  logic [SYS_W-1:0] sys_cnt_q, sys_cnt_d;
  logic [IFC_W-1:0] ifc_cnt_q, ifc_cnt_d;
  logic [MS_W-1:0]  now_q, now_d;
  logic [MIN_W-1:0] wait_min_q, wait_min_d;
  logic [SYS_W-1:0] step_q, step_d;
  logic [MS_W-1:0]  wait_ms_q, wait_ms_d;
  logic [MS_W-1:0]  iface_at_q, iface_at_d;
  action_e          action_q, action_d;
  logic             m_valid_q, m_valid_d;
  logic [55:0]      m_data_q, m_data_d;
  logic [1:0]       m_user_q, m_user_d;

  logic             in_acc;
  logic             cfg_wr;
  logic [MIN_W-1:0] mul_a;
  logic             mul_growth;
  logic [MS_W-1:0]  product;
  logic [MS_W-1:0]  age;
  logic [MS_W-1:0]  sys_at;
  logic [MS_W-1:0]  outage;

  enw_mul u_mul (
    .op_a_i       (mul_a),
    .sel_growth_i (mul_growth),
    .product_o    (product)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_wr        = psel && penable && pwrite && pready && (paddr[2] == REG_TIMEOUT);
  assign pready        = 1'b1;
  assign prdata        = (paddr[2] == REG_TIMEOUT) ? 32'(timeout_q) : 32'd0;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  assign age    = now_q - down_since_q;
  assign sys_at = iface_at_q + wait_ms_q;
  assign outage = is_down_q ? age : '0;

  always_comb begin
    mul_a      = wait_min_q;
    mul_growth = (state_q == ST_GROW);
    if (state_q == ST_SCALE_IFACE) begin
      mul_a = MIN_W'(timeout_q);
    end
  end

  always_comb begin
    state_d       = state_q;
    timeout_d     = timeout_q;
    is_down_d     = is_down_q;
    down_since_d  = down_since_q;
    iface_fired_d = iface_fired_q;
    sys_fired_d   = sys_fired_q;
    sys_cnt_d     = sys_cnt_q;
    ifc_cnt_d     = ifc_cnt_q;
    now_d         = now_q;
    wait_min_d    = wait_min_q;
    step_d        = step_q;
    wait_ms_d     = wait_ms_q;
    iface_at_d    = iface_at_q;
    action_d      = action_q;
    m_valid_d     = m_valid_q && !m_axis_tready;
    m_data_d      = m_data_q;
    m_user_d      = m_user_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          now_d    = s_axis_tdata;
          action_d = ACT_NONE;
          state_d  = ST_OUT;
          if (s_axis_tuser[0]) begin
            is_down_d     = 1'b0;
            iface_fired_d = 1'b0;
            sys_fired_d   = 1'b0;
            sys_cnt_d     = '0;
          end else begin
            if (!is_down_q) begin
              is_down_d    = 1'b1;
              down_since_d = s_axis_tdata;
            end
            if (timeout_q != '0) begin
              wait_min_d = MIN_W'(timeout_q);
              step_d     = '0;
              state_d    = ST_GROW;
            end
          end
        end
      end
      ST_GROW: begin
        if ((step_q == sys_cnt_q) || (wait_min_q == MAX_WAIT_MINUTES)) begin
          state_d = ST_SCALE_WAIT;
        end else begin
          wait_min_d = (product < MS_W'(MAX_WAIT_MINUTES)) ? product[MIN_W-1:0]
                                                           : MAX_WAIT_MINUTES;
          step_d     = step_q + 1'b1;
        end
      end
      ST_SCALE_WAIT: begin
        wait_ms_d = product;
        state_d   = ST_SCALE_IFACE;
      end
      ST_SCALE_IFACE: begin
        iface_at_d = product;
        state_d    = ST_DECIDE;
      end
      ST_DECIDE: begin
        priority if (!sys_fired_q && (age >= sys_at)) begin
          sys_fired_d   = 1'b1;
          iface_fired_d = 1'b1;
          if (sys_cnt_q != SYS_MAX) begin
            sys_cnt_d = sys_cnt_q + 1'b1;
          end
          action_d = ACT_SYSTEM;
        end else if (!iface_fired_q && (age >= iface_at_q)) begin
          iface_fired_d = 1'b1;
          if (ifc_cnt_q != IFC_MAX) begin
            ifc_cnt_d = ifc_cnt_q + 1'b1;
          end
          action_d = ACT_IFACE;
        end else begin
          action_d = ACT_NONE;
        end
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {sys_cnt_q, ifc_cnt_q, outage};
          m_user_d  = action_q;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_wr) begin
      timeout_d     = pwdata[TMO_W-1:0];
      iface_fired_d = 1'b0;
      sys_fired_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      timeout_q     <= '0;
      is_down_q     <= 1'b0;
      down_since_q  <= '0;
      iface_fired_q <= 1'b0;
      sys_fired_q   <= 1'b0;
      sys_cnt_q     <= '0;
      ifc_cnt_q     <= '0;
      action_q      <= ACT_NONE;
      m_valid_q     <= 1'b0;
    end else begin
      state_q       <= state_d;
      timeout_q     <= timeout_d;
      is_down_q     <= is_down_d;
      down_since_q  <= down_since_d;
      iface_fired_q <= iface_fired_d;
      sys_fired_q   <= sys_fired_d;
      sys_cnt_q     <= sys_cnt_d;
      ifc_cnt_q     <= ifc_cnt_d;
      action_q      <= action_d;
      m_valid_q     <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q      <= now_d;
    wait_min_q <= wait_min_d;
    step_q     <= step_d;
    wait_ms_q  <= wait_ms_d;
    iface_at_q <= iface_at_d;
    m_data_q   <= m_data_d;
    m_user_q   <= m_user_d;
  end

endmodule

### src/enw_mul.sv
// Shared 16 x 16 multiplier of the watchdog sequencer.
// Depends on enw_pkg for the growth factor and the minute scale.
module enw_mul import enw_pkg::*; (
  input  logic [MIN_W-1:0] op_a_i,
  input  logic             sel_growth_i,
  output logic [MS_W-1:0]  product_o
);

  logic [MIN_W-1:0] op_b;

  assign op_b      = sel_growth_i ? GROWTH : MS_PER_MINUTE;
  assign product_o = MS_W'(op_a_i) * MS_W'(op_b);

endmodule

### src/enw_checker.sv
// Port-level checker for the escalating network watchdog, bound to the top level.
// Depends on enw_pkg and escalating_network_watchdog.
module enw_checker import enw_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tvalid,
  input logic               s_axis_tready,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [55:0]        m_axis_tdata,
  input logic [1:0]         m_axis_tuser,
  input logic               psel,
  input logic               penable,
  input logic               pwrite,
  input logic [PADDR_W-1:0] paddr,
  input logic [31:0]        pwdata,
  input logic [31:0]        prdata,
  input logic               pready
);

  // The sequencer takes one request at a time.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while a request is in progress");

  a_action_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == ACT_NONE || m_axis_tuser == ACT_IFACE ||
                       m_axis_tuser == ACT_SYSTEM))
    else $error("undefined action code");

  // A system restart is always counted, up to saturation, in the same result.
  a_sys_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == ACT_SYSTEM) |-> (m_axis_tdata[55:48] != 8'd0))
    else $error("system restart reported with zero count");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

  a_reg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready && !paddr[2]) |=>
      (paddr[2] || (prdata == {24'd0, $past(pwdata[7:0])})))
    else $error("timeout register readback mismatch");

endmodule

bind escalating_network_watchdog enw_checker u_enw_checker (.*);
